// ----- sv/ssc_pkg.sv -----
// Shared types and constants for the sphere contact pipeline.
package ssc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W_POS     = 32;
    localparam int W_RAD     = 31;
    localparam int W_MAG     = 33;
    localparam int W_SQ      = 65;
    localparam int W_S       = 64;
    localparam int W_DIST    = 32;
    localparam int W_NRM     = 16;
    localparam int W_QUO     = 15;
    localparam int W_NUM     = 48;
    localparam int W_PROD    = 49;
    localparam int W_OVL     = 34;
    localparam int SQ_STEPS  = 32;
    localparam int NORM_SH   = 14;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;

    localparam logic signed [W_NRM-1:0] NORM_ONE = 16'sd16384;

    localparam longint SENT_RAW = longint'(100000) * (longint'(1) << FRAC_BITS);
    localparam longint OVL_LIM  = longint'(1) << (W_OVL - 1);
    localparam logic signed [W_OVL-1:0] OVL_MISS =
        W_OVL'(-((SENT_RAW > OVL_LIM) ? OVL_LIM : SENT_RAW));

    typedef enum logic [1:0] {
        K_MISS,
        K_ZERO,
        K_HIT
    } t_kind;

    // classified item handed from front to back
    typedef struct packed {
        t_kind                        kind;
        logic                         flag;
        logic [W_S-1:0]               s;
        logic [2:0][W_MAG-1:0]        mag;
        logic [2:0]                   neg;
        logic [2:0][W_POS-1:0]        base;
        logic [W_RAD-1:0]             ra;
        logic [W_DIST-1:0]            sum;
    } t_cls;

endpackage

// ----- sv/ssc_front.sv -----
// Front end: centre differences, squared distance and hit classification.
module ssc_front import ssc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic signed [W_POS-1:0] i_a_pos_x,
    input  logic signed [W_POS-1:0] i_a_pos_y,
    input  logic signed [W_POS-1:0] i_a_pos_z,
    input  logic [W_RAD-1:0]        i_a_radius,
    input  logic signed [W_POS-1:0] i_b_pos_x,
    input  logic signed [W_POS-1:0] i_b_pos_y,
    input  logic signed [W_POS-1:0] i_b_pos_z,
    input  logic [W_RAD-1:0]        i_b_radius,
    input  logic                    i_result_is_a,
    output logic                    o_q_push,
    output t_cls                    o_q_item,
    input  logic                    i_q_full
);

    logic signed [W_POS-1:0] w_a [3];
    logic signed [W_POS-1:0] w_b [3];
    logic signed [W_MAG-1:0] w_d [3];
    logic [W_MAG-1:0]        w_mag [3];
    logic                    w_zero;
    logic signed [W_POS:0]   w_ysum;
    logic [W_POS-1:0]        w_zy;
    logic                    w_en;
    t_cls                    w_c1;

    logic                    r_f1_v;
    t_cls                    r_f1_c;
    logic                    r_f2_v;
    t_cls                    r_f2_c;
    logic [W_SQ-1:0]         r_f2_sq [3];
    logic [W_S-1:0]          r_f2_sum2;
    logic [W_SQ+1:0]         w_s;

    assign w_en = !r_f2_v || !i_q_full;
    assign full = !w_en;

    assign w_a[0] = i_a_pos_x;
    assign w_a[1] = i_a_pos_y;
    assign w_a[2] = i_a_pos_z;
    assign w_b[0] = i_b_pos_x;
    assign w_b[1] = i_b_pos_y;
    assign w_b[2] = i_b_pos_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_d[k]   = {w_a[k][W_POS-1], w_a[k]} - {w_b[k][W_POS-1], w_b[k]};
            w_mag[k] = w_d[k][W_MAG-1] ? W_MAG'(-w_d[k]) : W_MAG'(w_d[k]);
        end
        w_zero = (w_d[0] == '0) && (w_d[1] == '0) && (w_d[2] == '0);
        w_ysum = {i_a_pos_y[W_POS-1], i_a_pos_y} + $signed({2'b00, i_a_radius});
        // only upward overflow is possible
        w_zy   = (!w_ysum[W_POS] && w_ysum[W_POS-1]) ? {1'b0, {(W_POS-1){1'b1}}}
                                                      : w_ysum[W_POS-1:0];
    end

    always_comb begin
        w_c1      = '0;
        w_c1.kind = w_zero ? K_ZERO : K_HIT;
        w_c1.flag = i_result_is_a;
        for (int k = 0; k < 3; k++) begin
            w_c1.mag[k] = w_mag[k];
            w_c1.neg[k] = w_d[k][W_MAG-1];
        end
        w_c1.base[0] = w_zero ? i_a_pos_x : i_b_pos_x;
        w_c1.base[1] = w_zero ? w_zy      : i_b_pos_y;
        w_c1.base[2] = w_zero ? i_a_pos_z : i_b_pos_z;
        w_c1.ra      = i_a_radius;
        w_c1.sum     = {1'b0, i_a_radius} + {1'b0, i_b_radius};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (w_en) begin
            r_f1_v <= push;
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_c <= w_c1;
            r_f2_c <= r_f1_c;
            for (int k = 0; k < 3; k++) begin
                r_f2_sq[k] <= W_SQ'(r_f1_c.mag[k] * r_f1_c.mag[k]);
            end
            r_f2_sum2 <= W_S'(r_f1_c.sum * r_f1_c.sum);
        end
    end

    always_comb begin
        w_s      = {2'b00, r_f2_sq[0]} + {2'b00, r_f2_sq[1]} + {2'b00, r_f2_sq[2]};
        o_q_item = r_f2_c;
        o_q_item.s = w_s[W_S-1:0];
        if (r_f2_c.kind != K_ZERO) begin
            o_q_item.kind = (w_s < {3'b000, r_f2_sum2}) ? K_HIT : K_MISS;
        end
    end

    assign o_q_push = r_f2_v && !i_q_full;

endmodule

// ----- sv/ssc_queue.sv -----
// Short item queue between the front and back ends.
module ssc_queue import ssc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_item,
    output logic o_full,
    input  logic i_pop,
    output t_cls o_item,
    output logic o_empty
);

    t_cls            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

endmodule

// ----- sv/ssc_back.sv -----
// Back end: pipelined square root, normal division, contact point and result register.
module ssc_back import ssc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cls                    i_q_item,
    input  logic                    i_q_empty,
    output logic                    o_q_pop,
    output logic                    empty,
    input  logic                    pop,
    output logic                    o_hit,
    output logic signed [W_NRM-1:0] o_normal_x,
    output logic signed [W_NRM-1:0] o_normal_y,
    output logic signed [W_NRM-1:0] o_normal_z,
    output logic signed [W_POS-1:0] o_point_x,
    output logic signed [W_POS-1:0] o_point_y,
    output logic signed [W_POS-1:0] o_point_z,
    output logic signed [W_OVL-1:0] o_overlap,
    output logic                    o_penetrates_other
);

    logic w_en;

    // square root stages
    logic              r_sq_v    [SQ_STEPS+1];
    t_cls              r_sq_c    [SQ_STEPS+1];
    logic [W_DIST+1:0] r_sq_rem  [SQ_STEPS+1];
    logic [W_DIST-1:0] r_sq_root [SQ_STEPS+1];
    logic [W_S-1:0]    r_sq_rad  [SQ_STEPS+1];

    // division stages
    logic              r_dv_v    [W_QUO+1];
    t_cls              r_dv_c    [W_QUO+1];
    logic [W_DIST-1:0] r_dv_dist [W_QUO+1];
    logic [W_DIST:0]   r_dv_den  [W_QUO+1];
    logic [W_NUM-1:0]  r_dv_rem  [W_QUO+1][3];
    logic [W_QUO-1:0]  r_dv_q    [W_QUO+1][3];

    // multiply stage
    logic                     r_mu_v;
    t_cls                     r_mu_c;
    logic [W_DIST-1:0]        r_mu_dist;
    logic signed [W_NRM-1:0]  r_mu_n [3];
    logic signed [W_PROD-1:0] r_mu_p [3];

    logic                     r_out_v;

    assign w_en    = !r_out_v || pop;
    assign empty   = !r_out_v;
    assign o_q_pop = w_en && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= SQ_STEPS; j++) r_sq_v[j] <= 1'b0;
            for (int j = 0; j <= W_QUO; j++)    r_dv_v[j] <= 1'b0;
            r_mu_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_sq_v[0] <= !i_q_empty;
            for (int j = 0; j < SQ_STEPS; j++) r_sq_v[j+1] <= r_sq_v[j];
            r_dv_v[0] <= r_sq_v[SQ_STEPS];
            for (int j = 0; j < W_QUO; j++)    r_dv_v[j+1] <= r_dv_v[j];
            r_mu_v  <= r_dv_v[W_QUO];
            r_out_v <= r_mu_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_c[0]    <= i_q_item;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_rad[0]  <= i_q_item.s;
        end
    end

    // two radicand bits per stage
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        logic [W_DIST+3:0] w_sh;
        logic [W_DIST+3:0] w_trial;
        logic              w_ge;

        always_comb begin
            w_sh    = {r_sq_rem[j], r_sq_rad[j][W_S-1:W_S-2]};
            w_trial = {2'b00, r_sq_root[j], 2'b01};
            w_ge    = (w_sh >= w_trial);
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_c[j+1]    <= r_sq_c[j];
                r_sq_rem[j+1]  <= w_ge ? (W_DIST+2)'(w_sh - w_trial) : (W_DIST+2)'(w_sh);
                r_sq_root[j+1] <= {r_sq_root[j][W_DIST-2:0], w_ge};
                r_sq_rad[j+1]  <= {r_sq_rad[j][W_S-3:0], 2'b00};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_c[0]    <= r_sq_c[SQ_STEPS];
            r_dv_dist[0] <= r_sq_root[SQ_STEPS];
            r_dv_den[0]  <= {r_sq_root[SQ_STEPS], 1'b0};
            for (int k = 0; k < 3; k++) begin
                r_dv_rem[0][k] <= {r_sq_c[SQ_STEPS].mag[k], {W_QUO{1'b0}}}
                                  + W_NUM'(r_sq_root[SQ_STEPS]);
                r_dv_q[0][k]   <= '0;
            end
        end
    end

    // quotient stays below 2^15 since each |d| is at most the distance
    for (genvar j = 0; j < W_QUO; j++) begin : g_div
        logic [W_NUM-1:0] w_den_sh;
        logic [2:0]       w_ge;

        always_comb begin
            w_den_sh = W_NUM'(r_dv_den[j]) << (W_QUO - 1 - j);
            for (int k = 0; k < 3; k++) w_ge[k] = (r_dv_rem[j][k] >= w_den_sh);
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_c[j+1]    <= r_dv_c[j];
                r_dv_dist[j+1] <= r_dv_dist[j];
                r_dv_den[j+1]  <= r_dv_den[j];
                for (int k = 0; k < 3; k++) begin
                    r_dv_rem[j+1][k] <= w_ge[k] ? r_dv_rem[j][k] - w_den_sh : r_dv_rem[j][k];
                    r_dv_q[j+1][k]   <= {r_dv_q[j][k][W_QUO-2:0], w_ge[k]};
                end
            end
        end
    end

    logic signed [W_NRM-1:0] w_n [3];
    logic signed [W_MAG-1:0] w_k;

    always_comb begin
        w_k = $signed({1'b0, r_dv_dist[W_QUO]}) - $signed({2'b00, r_dv_c[W_QUO].ra});
        for (int k = 0; k < 3; k++) begin
            w_n[k] = r_dv_c[W_QUO].neg[k] ? -$signed({1'b0, r_dv_q[W_QUO][k]})
                                          :  $signed({1'b0, r_dv_q[W_QUO][k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mu_c    <= r_dv_c[W_QUO];
            r_mu_dist <= r_dv_dist[W_QUO];
            for (int k = 0; k < 3; k++) begin
                r_mu_n[k] <= w_n[k];
                r_mu_p[k] <= W_PROD'(w_n[k]) * W_PROD'(w_k);
            end
        end
    end

    logic signed [W_PROD:0]   w_rnd [3];
    logic signed [W_POS+5:0]  w_pt  [3];
    logic signed [W_POS-1:0]  w_sat [3];
    logic signed [W_NRM-1:0]  w_nf  [3];
    logic signed [W_POS-1:0]  w_pf  [3];
    logic signed [W_OVL-1:0]  w_ovl;
    logic                     w_hit;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rnd[k] = {r_mu_p[k][W_PROD-1], r_mu_p[k]} + (W_PROD+1)'(1 << (NORM_SH - 1));
            w_pt[k]  = (W_POS+6)'(w_rnd[k] >>> NORM_SH)
                       + (W_POS+6)'($signed(r_mu_c.base[k]));
            if (w_pt[k] > (W_POS+6)'(64'sd2147483647))       w_sat[k] = 32'sh7FFFFFFF;
            else if (w_pt[k] < (W_POS+6)'(-64'sd2147483648)) w_sat[k] = 32'sh80000000;
            else                                              w_sat[k] = w_pt[k][W_POS-1:0];
        end
        w_hit = 1'b1;
        w_ovl = OVL_MISS;
        for (int k = 0; k < 3; k++) begin
            w_nf[k] = '0;
            w_pf[k] = '0;
        end
        unique case (r_mu_c.kind)
            K_ZERO: begin
                w_nf[1] = NORM_ONE;
                for (int k = 0; k < 3; k++) w_pf[k] = r_mu_c.base[k];
                w_ovl = -$signed({3'b000, r_mu_c.ra});
            end
            K_HIT: begin
                for (int k = 0; k < 3; k++) begin
                    w_nf[k] = r_mu_n[k];
                    w_pf[k] = w_sat[k];
                end
                w_ovl = $signed({2'b00, r_mu_dist}) - $signed({2'b00, r_mu_c.sum});
            end
            default: w_hit = 1'b0;
        endcase
        if (w_hit && !r_mu_c.flag) begin
            for (int k = 0; k < 3; k++) w_nf[k] = -w_nf[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_hit              <= w_hit;
            o_normal_x         <= w_nf[0];
            o_normal_y         <= w_nf[1];
            o_normal_z         <= w_nf[2];
            o_point_x          <= w_pf[0];
            o_point_y          <= w_pf[1];
            o_point_z          <= w_pf[2];
            o_overlap          <= w_ovl;
            o_penetrates_other <= w_hit && r_mu_c.flag;
        end
    end

endmodule

// ----- sv/sphere_sphere_contact.sv -----
// 54 register stages: 2 front, queue entry, 33 square root, 16 divider, multiply, result.
// Throughput: one item per cycle while pop does not hold the result register;
// the pipelined square root and divider take one a cycle.
// The 4-entry queue lets the front keep taking items while the back is held by pop.
// Reset (i_rst_n low, synchronous) empties the pipeline and the queue; payload is not reset.
module sphere_sphere_contact import ssc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic signed [W_POS-1:0] i_a_pos_x,
    input  logic signed [W_POS-1:0] i_a_pos_y,
    input  logic signed [W_POS-1:0] i_a_pos_z,
    input  logic [W_RAD-1:0]        i_a_radius,
    input  logic signed [W_POS-1:0] i_b_pos_x,
    input  logic signed [W_POS-1:0] i_b_pos_y,
    input  logic signed [W_POS-1:0] i_b_pos_z,
    input  logic [W_RAD-1:0]        i_b_radius,
    input  logic                    i_result_is_a,
    output logic                    empty,
    input  logic                    pop,
    output logic                    o_hit,
    output logic signed [W_NRM-1:0] o_normal_x,
    output logic signed [W_NRM-1:0] o_normal_y,
    output logic signed [W_NRM-1:0] o_normal_z,
    output logic signed [W_POS-1:0] o_point_x,
    output logic signed [W_POS-1:0] o_point_y,
    output logic signed [W_POS-1:0] o_point_z,
    output logic signed [W_OVL-1:0] o_overlap,
    output logic                    o_penetrates_other
);

    logic w_q_push;
    logic w_q_full;
    logic w_q_pop;
    logic w_q_empty;
    t_cls w_q_in;
    t_cls w_q_out;

    ssc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_a_pos_x     (i_a_pos_x),
        .i_a_pos_y     (i_a_pos_y),
        .i_a_pos_z     (i_a_pos_z),
        .i_a_radius    (i_a_radius),
        .i_b_pos_x     (i_b_pos_x),
        .i_b_pos_y     (i_b_pos_y),
        .i_b_pos_z     (i_b_pos_z),
        .i_b_radius    (i_b_radius),
        .i_result_is_a (i_result_is_a),
        .o_q_push      (w_q_push),
        .o_q_item      (w_q_in),
        .i_q_full      (w_q_full)
    );

    ssc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_item  (w_q_out),
        .o_empty (w_q_empty)
    );

    ssc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_item           (w_q_out),
        .i_q_empty          (w_q_empty),
        .o_q_pop            (w_q_pop),
        .empty              (empty),
        .pop                (pop),
        .o_hit              (o_hit),
        .o_normal_x         (o_normal_x),
        .o_normal_y         (o_normal_y),
        .o_normal_z         (o_normal_z),
        .o_point_x          (o_point_x),
        .o_point_y          (o_point_y),
        .o_point_z          (o_point_z),
        .o_overlap          (o_overlap),
        .o_penetrates_other (o_penetrates_other)
    );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the sphere-versus-sphere contact pipeline.
module testbench;
    import ssc_pkg::*;

    localparam int CYCLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic signed [W_POS-1:0] i_a_pos_x = '0, i_a_pos_y = '0, i_a_pos_z = '0;
    logic signed [W_POS-1:0] i_b_pos_x = '0, i_b_pos_y = '0, i_b_pos_z = '0;
    logic [W_RAD-1:0] i_a_radius = '0, i_b_radius = '0;
    logic i_result_is_a = 1'b0;
    logic o_hit, o_penetrates_other;
    logic signed [W_NRM-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic signed [W_POS-1:0] o_point_x, o_point_y, o_point_z;
    logic signed [W_OVL-1:0] o_overlap;

    typedef struct {
        logic signed [W_POS-1:0] ax, ay, az, bx, by, bz;
        logic [W_RAD-1:0] ra, rb;
        logic flag;
    } pair_t;

    typedef struct {
        logic hit;
        logic signed [W_NRM-1:0] nx, ny, nz;
        logic signed [W_POS-1:0] px, py, pz;
        logic signed [W_OVL-1:0] ovl;
        logic pen;
    } contact_t;

    contact_t contacts_due[$];
    int errors = 0;
    int send_idle = 0;
    int take_idle = 0;
    int hold_off = 0;
    int quiet_cycles = 0;

    sphere_sphere_contact DUT (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor((x + 2^13) / 2^14)
    function automatic longint round_half_up(input longint x);
        return (x + 8192) >>> 14;
    endfunction

    function automatic contact_t predict_contact(input pair_t s);
        contact_t c;
        longint a[3], b[3], d[3], n[3], p[3];
        logic [127:0] dsq;
        longint sum, ovl, k;
        logic [63:0] root_d, m, q;
        a = '{s.ax, s.ay, s.az};
        b = '{s.bx, s.by, s.bz};
        n = '{0, 0, 0};
        p = '{0, 0, 0};
        sum = longint'(s.ra) + longint'(s.rb);
        dsq = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = a[i] - b[i];
            m = d[i] < 0 ? -d[i] : d[i];
            dsq += 128'(m) * 128'(m);
        end
        c.hit = 1'b0;
        ovl = -((longint'(100000) << 16) > (longint'(1) << 33) ?
                (longint'(1) << 33) : (longint'(100000) << 16));
        if (dsq == 0) begin
            c.hit = 1'b1;
            n[1] = 16384;
            p[0] = a[0];
            p[1] = clip32(a[1] + longint'(s.ra));
            p[2] = a[2];
            ovl = -longint'(s.ra);
        end else if (dsq < 128'(sum) * 128'(sum)) begin
            c.hit = 1'b1;
            root_d = int_sqrt(dsq[63:0]);
            ovl = longint'(root_d) - sum;
            k = longint'(s.rb) + ovl;
            for (int i = 0; i < 3; i++) begin
                m = d[i] < 0 ? -d[i] : d[i];
                q = (m * 32768 + root_d) / (2 * root_d);
                n[i] = d[i] < 0 ? -longint'(q) : longint'(q);
                p[i] = clip32(b[i] + round_half_up(n[i] * k));
            end
        end
        if (c.hit && !s.flag) for (int i = 0; i < 3; i++) n[i] = -n[i];
        c.nx = W_NRM'(n[0]); c.ny = W_NRM'(n[1]); c.nz = W_NRM'(n[2]);
        c.px = W_POS'(p[0]); c.py = W_POS'(p[1]); c.pz = W_POS'(p[2]);
        c.ovl = W_OVL'(ovl);
        c.pen = c.hit & s.flag;
        return c;
    endfunction

    // push stays high from one item to the next; it drops only while idling
    task automatic send_pair(input pair_t s);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_a_pos_x <= s.ax; i_a_pos_y <= s.ay; i_a_pos_z <= s.az; i_a_radius <= s.ra;
        i_b_pos_x <= s.bx; i_b_pos_y <= s.by; i_b_pos_z <= s.bz; i_b_radius <= s.rb;
        i_result_is_a <= s.flag;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        contacts_due.push_back(predict_contact(s));
    endtask

    function automatic logic [W_POS-1:0] rand_coord(input int spread);
        case ($urandom_range(3))
            0: return $urandom;
            default: return $signed($urandom_range(2 * spread)) - spread;
        endcase
    endfunction

    function automatic pair_t rand_pair();
        pair_t s;
        int spread;
        spread = ($urandom_range(3) == 0) ? 32'h3fff_ffff : (1 << $urandom_range(6, 24));
        s.ax = rand_coord(spread); s.ay = rand_coord(spread); s.az = rand_coord(spread);
        s.bx = s.ax + rand_coord(spread);
        s.by = s.ay + rand_coord(spread);
        s.bz = s.az + rand_coord(spread);
        s.ra = ($urandom_range(4) == 0) ? W_RAD'($urandom) : W_RAD'($urandom_range(spread));
        s.rb = ($urandom_range(4) == 0) ? W_RAD'($urandom) : W_RAD'($urandom_range(spread));
        if ($urandom_range(15) == 0) begin
            s.bx = s.ax; s.by = s.ay; s.bz = s.az;
        end
        s.flag = 1'($urandom_range(1));
        return s;
    endfunction

    task automatic wait_drained();
        push <= 1'b0;
        while (contacts_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        pair_t s;
        s = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_pair(s);                          // coincident, zero radii
        s.ra = 31'h7fff_ffff; s.ay = 32'sh7fff_0000; s.flag = 1;
        s.by = s.ay; send_pair(s);             // coincident, y saturates
        s = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
              31'h7fff_ffff, 31'h7fff_ffff, 1};
        send_pair(s);                          // widest separation, miss
        s.flag = 0; send_pair(s);
        s = '{32'sh0001_0000, 0, 0, 0, 0, 0, 31'h0001_0000, 31'h0001_0000, 0};
        send_pair(s);                          // hit along x
        s.flag = 1; send_pair(s);
        s = '{0, -32'sh0003_0000, 0, 0, 0, 0, 31'h0001_0000, 31'h0002_0000, 1};
        send_pair(s);                          // just touching: miss
        s.rb = 31'h0002_0001; send_pair(s);
        s = '{5, -7, 3, -2, 4, -9, 20, 1, 0};
        send_pair(s);                          // tiny distances, rounding
        s = '{32'sh7fff_ffff, 0, 0, 32'sh7fff_0000, 0, 0, 0, 31'h7fff_ffff, 0};
        send_pair(s);                          // point lands on the upper limit
        s = '{-32'sh7fff_0000, 0, 0, -32'sh7fff_ffff, 0, 0, 0, 31'h7fff_ffff, 1};
        send_pair(s);
        s = '{1000, 1000, 1000, 0, 0, 0, 31'h0000_1000, 0, 1};
        send_pair(s);                          // diagonal
        wait_drained();
    endtask

    task automatic test_random(input int count, input int s_idle, input int r_idle);
        send_idle = s_idle;
        take_idle = r_idle;
        repeat (count) send_pair(rand_pair());
    endtask

    task automatic test_backpressure();
        send_idle = 0;
        take_idle = 0;
        hold_off = 200;
        repeat (100) send_pair(rand_pair());
        wait_drained();                        // sender pauses until all results are in
    endtask

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            pop <= 1'b0;
        end else begin
            pop <= !(take_idle > 0 && $urandom_range(99) < take_idle);
        end
    end

    always @(posedge i_clk) begin
        contact_t e;
        if (i_rst_n && pop && !empty) begin
            if (contacts_due.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                e = contacts_due.pop_front();
                if (o_hit !== e.hit) begin
                    $error("hit: expected %0d got %0d", e.hit, o_hit); errors++;
                end
                if (o_normal_x !== e.nx) begin
                    $error("normal_x: expected %0d got %0d", e.nx, o_normal_x); errors++;
                end
                if (o_normal_y !== e.ny) begin
                    $error("normal_y: expected %0d got %0d", e.ny, o_normal_y); errors++;
                end
                if (o_normal_z !== e.nz) begin
                    $error("normal_z: expected %0d got %0d", e.nz, o_normal_z); errors++;
                end
                if (o_point_x !== e.px) begin
                    $error("point_x: expected %0d got %0d", e.px, o_point_x); errors++;
                end
                if (o_point_y !== e.py) begin
                    $error("point_y: expected %0d got %0d", e.py, o_point_y); errors++;
                end
                if (o_point_z !== e.pz) begin
                    $error("point_z: expected %0d got %0d", e.pz, o_point_z); errors++;
                end
                if (o_overlap !== e.ovl) begin
                    $error("overlap: expected %0d got %0d", e.ovl, o_overlap); errors++;
                end
                if (o_penetrates_other !== e.pen) begin
                    $error("penetrates_other: expected %0d got %0d",
                           e.pen, o_penetrates_other);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= CYCLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(230, 37, 49);
        test_random(230, 49, 37);
        test_backpressure();
        test_random(230, 0, 0);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && contacts_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
